@@ hdl/mspg_pkg.sv @@
// ----------------------------------------------------------------------------
// mspg_pkg
// Shared sizes, codes and types of the multi-channel step pulse generator.
// ----------------------------------------------------------------------------
package mspg_pkg;

    localparam int CHANNELS    = 4;
    localparam int CH_BITS     = 2;
    localparam int STEP_BITS   = 24;
    localparam int PERIOD_BITS = 16;
    localparam int MASK_BITS   = 4;

    localparam int CFG_ADDR_BITS = 1;
    localparam int CFG_DATA_BITS = 4;

    localparam int IN_TDATA_BITS  = 48;
    localparam int IN_TUSER_BITS  = 1;
    localparam int OUT_TDATA_BITS = 16;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_BITS-1:0] CFG_ENABLED_MASK = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_REVERSE_MASK = 1'b1;

    // Item kinds carried on tuser.
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // Command from the item stage to one channel.
    typedef struct packed {
        logic                   tick;
        logic                   load;
        logic [STEP_BITS-1:0]   goal;
        logic [PERIOD_BITS-1:0] period;
        logic                   heading;
    } t_ch_cmd;

    // Levels and flags of one channel after the current item.
    typedef struct packed {
        logic step;
        logic dir;
        logic finished;
        logic busy;
    } t_ch_status;

endpackage

@@ hdl/mspg_channel.sv @@
// ----------------------------------------------------------------------------
// mspg_channel
// One motor channel: move counters, period timer and step/direction pins.
// ----------------------------------------------------------------------------
module mspg_channel
    import mspg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ch_cmd    i_cmd,
    output t_ch_status o_status
);

    logic                   r_running, n_running;
    logic [STEP_BITS-1:0]   r_done,    n_done;
    logic [STEP_BITS-1:0]   r_goal,    n_goal;
    logic [PERIOD_BITS-1:0] r_ticks,   n_ticks;
    logic [PERIOD_BITS-1:0] r_period,  n_period;
    logic                   r_heading, n_heading;
    logic                   r_step,    n_step;
    logic                   r_dir,     n_dir;
    logic                   finished;

    always_comb begin
        n_running = r_running;
        n_done    = r_done;
        n_goal    = r_goal;
        n_ticks   = r_ticks;
        n_period  = r_period;
        n_heading = r_heading;
        n_step    = r_step;
        n_dir     = r_dir;
        finished  = 1'b0;
        if (i_cmd.load) begin
            // A load replaces any move in progress but leaves the pins alone.
            n_running = 1'b1;
            n_done    = '0;
            n_ticks   = '0;
            n_goal    = i_cmd.goal;
            n_period  = i_cmd.period;
            n_heading = i_cmd.heading;
        end else if (i_cmd.tick && r_running) begin
            n_step = 1'b0;
            if (r_done == r_goal) begin
                n_running = 1'b0;
                n_done    = '0;
                n_goal    = '0;
                n_ticks   = '0;
                n_period  = '0;
                finished  = 1'b1;
            end else if (r_ticks == r_period) begin
                n_ticks = '0;
                n_done  = r_done + STEP_BITS'(1);
                n_dir   = r_heading;
                n_step  = 1'b1;
            end else begin
                n_ticks = r_ticks + PERIOD_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_done    <= '0;
            r_goal    <= '0;
            r_ticks   <= '0;
            r_period  <= '0;
            r_heading <= 1'b0;
            r_step    <= 1'b0;
            r_dir     <= 1'b0;
        end else begin
            r_running <= n_running;
            r_done    <= n_done;
            r_goal    <= n_goal;
            r_ticks   <= n_ticks;
            r_period  <= n_period;
            r_heading <= n_heading;
            r_step    <= n_step;
            r_dir     <= n_dir;
        end
    end

    assign o_status.step     = n_step;
    assign o_status.dir      = n_dir;
    assign o_status.finished = finished;
    assign o_status.busy     = n_running;

endmodule

@@ hdl/multi_channel_step_pulse_generator.sv @@
// ----------------------------------------------------------------------------
// multi_channel_step_pulse_generator
// Step and direction pulse generator for several motor channels.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_axis    in         tuser: kind; tdata: channel, step_count, step interval,
//                       moving_positive
//  m_axis    out        tdata: step_outputs, dir_outputs, finished_mask,
//                       busy_mask
//  cfg       in         i_cfg_addr selects enabled_mask or reverse_mask
//
// One beat is taken per cycle while the output is not stalled. An accepted beat
// sits in the input register until the output register can take it; then all
// channels update in parallel and the result lands in the output register,
// which drives m_axis_tvalid.
// A stalled output register holds the input register, which in turn drops
// s_axis_tready. Synchronous reset clears all channels, pins and masks.
// ----------------------------------------------------------------------------
module multi_channel_step_pulse_generator
    import mspg_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_wdata,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // [1:0] channel, [25:2] step_count, [41:26] step interval,
    // [42] moving_positive, [47:43] zero
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
    // [0] kind
    input  logic [IN_TUSER_BITS-1:0]  s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [3:0] step_outputs, [7:4] dir_outputs, [11:8] finished_mask,
    // [15:12] busy_mask
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);

    logic [MASK_BITS-1:0] r_enabled_mask;
    logic [MASK_BITS-1:0] r_reverse_mask;

    logic                   r_in_valid;
    logic                   r_in_kind;
    logic [CH_BITS-1:0]     r_in_channel;
    logic [STEP_BITS-1:0]   r_in_count;
    logic [PERIOD_BITS-1:0] r_in_period;
    logic                   r_in_positive;

    logic                      r_out_valid;
    logic [OUT_TDATA_BITS-1:0] r_out_data;

    logic                advance;
    t_ch_cmd             cmd    [CHANNELS];
    t_ch_status          status [CHANNELS];
    logic [CHANNELS-1:0] step_bits, dir_bits, fin_bits, busy_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled_mask <= '0;
            r_reverse_mask <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ENABLED_MASK: r_enabled_mask <= i_cfg_wdata;
                CFG_REVERSE_MASK: r_reverse_mask <= i_cfg_wdata;
            endcase
        end
    end

    // The held beat is processed whenever the output register can take it.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind     <= s_axis_tuser[0];
            r_in_channel  <= s_axis_tdata[CH_BITS-1:0];
            r_in_count    <= s_axis_tdata[CH_BITS +: STEP_BITS];
            r_in_period   <= s_axis_tdata[CH_BITS+STEP_BITS +: PERIOD_BITS];
            r_in_positive <= s_axis_tdata[CH_BITS+STEP_BITS+PERIOD_BITS];
        end
    end

    for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
        always_comb begin
            cmd[c].tick    = advance && (r_in_kind == KIND_TICK);
            cmd[c].load    = advance && (r_in_kind == KIND_LOAD)
                             && r_enabled_mask[c]
                             && (r_in_channel == CH_BITS'(c));
            cmd[c].goal    = r_in_count;
            cmd[c].period  = r_in_period;
            cmd[c].heading = r_in_positive ^ r_reverse_mask[c];
        end

        mspg_channel u_channel (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (cmd[c]),
            .o_status (status[c])
        );

        assign step_bits[c] = status[c].step;
        assign dir_bits[c]  = status[c].dir;
        assign fin_bits[c]  = status[c].finished;
        assign busy_bits[c] = status[c].busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {MASK_BITS'(busy_bits), MASK_BITS'(fin_bits),
                           MASK_BITS'(dir_bits), MASK_BITS'(step_bits)};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
